>>> hdl/pwli_pkg.sv
// shared constants and types of the piecewise linear interpolator
package pwli_pkg;

  localparam int MAX_POINTS = 16;
  localparam int VALUE_W    = 32;
  localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int CFG_PIU_W  = 5;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int PIDX_W     = 4;

  localparam int DIFF_W     = VALUE_W + 1;
  localparam int HALF_W     = DIFF_W / 2;
  localparam int HI_W       = DIFF_W - HALF_W;
  localparam int PP_W       = DIFF_W + HI_W;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int DCNT_W     = $clog2(DIFF_W + 1);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  localparam logic REG_POINTS_IN_USE = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_MUL0,
    ST_MUL1,
    ST_DIV,
    ST_FIN
  } pwli_state_t;

endpackage

>>> hdl/piecewise_linear_interpolator.sv
// piecewise linear interpolator: breakpoint table, segment search, multiply and divide
//
// A load word (opcode 0) writes one breakpoint and busy stays low.
// An evaluate word (opcode 1) scans the table one entry per cycle, from slot 0,
// through the x memory's single read port. With an empty table the result follows
// in the cycle after acceptance. A hit on slot 0, or a query above the last used x,
// finishes with the y value of the slot where the scan stops.
// Otherwise a 33x17 multiply in ST_MUL0 and ST_MUL1, a restoring divider giving one
// quotient bit per cycle and the final add in ST_FIN follow. The result is shown
// on the out_ ports for one cycle, marked by out_valid, in the same cycle as busy
// falls; it cannot be held off, so a result must be taken when it appears. A new
// word may be started in that same cycle.
module piecewise_linear_interpolator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_opcode,
  input  logic [pwli_pkg::PIDX_W-1:0]          in_point_index,
  input  logic signed [pwli_pkg::VALUE_W-1:0]  in_x_value,
  input  logic signed [pwli_pkg::VALUE_W-1:0]  in_y_value,
  output logic                                 out_valid,
  output logic signed [pwli_pkg::VALUE_W-1:0]  out_y_result,
  output logic                                 out_status,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pwli_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [pwli_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [pwli_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready
);
  import pwli_pkg::*;

  logic signed [VALUE_W-1:0] x_mem [MAX_POINTS];
  logic signed [VALUE_W-1:0] y_mem [MAX_POINTS];
  logic signed [VALUE_W-1:0] x_rd_r, y_rd_r;
  logic [IDX_W-1:0]          rd_addr;
  logic                      wr_en;
  logic [IDX_W-1:0]          wr_addr;

  pwli_state_t state_r, state_nxt;
  logic [IDX_W-1:0]          k_r, k_nxt;
  logic signed [VALUE_W-1:0] q_r, q_nxt;
  logic signed [VALUE_W-1:0] x_prev_r, x_prev_nxt;
  logic signed [VALUE_W-1:0] y_prev_r, y_prev_nxt;
  logic                      neg_r, neg_nxt;
  logic [DIFF_W-1:0]         a_r, a_nxt;
  logic [DIFF_W-1:0]         b_r, b_nxt;
  logic [DIFF_W-1:0]         dx_r, dx_nxt;
  logic [PROD_W-1:0]         acc_r, acc_nxt;
  logic [DIFF_W-1:0]         rem_r, rem_nxt;
  logic [DIFF_W-1:0]         dq_r, dq_nxt;
  logic [DCNT_W-1:0]         cnt_r, cnt_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0] out_y_r, out_y_nxt;
  logic                      out_status_r, out_status_nxt;
  logic [CFG_PIU_W-1:0]      piu_r, piu_nxt;

  logic                      accept;
  logic                      cfg_wr;
  logic [CNT_W-1:0]          n_eff;
  logic signed [DIFF_W-1:0]  dy_s, dx_s, t_s;
  logic [HI_W-1:0]           mul_b;
  logic [PP_W-1:0]           pp;
  logic [PROD_W-1:0]         prod_full;
  logic [DIFF_W:0]           trial;
  logic [DIFF_W-1:0]         qv;
  logic [DIFF_W-1:0]         sum;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_POINTS_IN_USE) ? CFG_DATA_W'(piu_r) : '0;

  assign out_valid    = out_valid_r;
  assign out_y_result = out_y_r;
  assign out_status   = out_status_r;

  assign n_eff = (int'(piu_r) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : CNT_W'(piu_r);

  assign wr_en   = accept && (in_opcode == OP_LOAD) && (int'(in_point_index) < MAX_POINTS);
  assign wr_addr = IDX_W'(in_point_index);
  assign rd_addr = (state_r == ST_SRCH) ? IDX_W'(k_r + IDX_W'(1)) : '0;

  // breakpoint tables
  always_ff @(posedge clk) begin
    if (wr_en) begin
      x_mem[wr_addr] <= in_x_value;
      y_mem[wr_addr] <= in_y_value;
    end
    x_rd_r <= x_mem[rd_addr];
    y_rd_r <= y_mem[rd_addr];
  end

  assign dy_s = {y_rd_r[VALUE_W-1], y_rd_r} - {y_prev_r[VALUE_W-1], y_prev_r};
  assign dx_s = {x_rd_r[VALUE_W-1], x_rd_r} - {x_prev_r[VALUE_W-1], x_prev_r};
  assign t_s  = {q_r[VALUE_W-1], q_r} - {x_prev_r[VALUE_W-1], x_prev_r};

  // shared multiplier, low half then high half of the offset
  assign mul_b     = (state_r == ST_MUL0) ? HI_W'(b_r[HALF_W-1:0]) : b_r[DIFF_W-1:HALF_W];
  assign pp        = PP_W'(a_r) * PP_W'(mul_b);
  assign prod_full = acc_r + (PROD_W'(pp) << HALF_W);

  assign trial = {rem_r, dq_r[DIFF_W-1]} - {1'b0, dx_r};
  assign qv    = (dx_r == '0) ? '0 : dq_r;
  assign sum   = {y_prev_r[VALUE_W-1], y_prev_r} + (neg_r ? (~qv + DIFF_W'(1)) : qv);

  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    q_nxt          = q_r;
    x_prev_nxt     = x_prev_r;
    y_prev_nxt     = y_prev_r;
    neg_nxt        = neg_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    dx_nxt         = dx_r;
    acc_nxt        = acc_r;
    rem_nxt        = rem_r;
    dq_nxt         = dq_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = 1'b0;
    out_y_nxt      = out_y_r;
    out_status_nxt = out_status_r;
    piu_nxt        = piu_r;

    if (cfg_wr && (paddr[2] == REG_POINTS_IN_USE)) begin
      piu_nxt = pwdata[CFG_PIU_W-1:0];
    end

    case (state_r)
      ST_IDLE: begin
        if (accept && (in_opcode == OP_EVAL)) begin
          q_nxt = in_x_value;
          k_nxt = '0;
          if (n_eff == '0) begin
            out_valid_nxt  = 1'b1;
            out_y_nxt      = '0;
            out_status_nxt = STATUS_EMPTY;
          end else begin
            state_nxt = ST_SRCH;
          end
        end
      end
      ST_SRCH: begin
        if (x_rd_r >= q_r) begin
          if (k_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_y_nxt      = y_rd_r;
            out_status_nxt = STATUS_OK;
            state_nxt      = ST_IDLE;
          end else begin
            neg_nxt   = dy_s[DIFF_W-1];
            a_nxt     = dy_s[DIFF_W-1] ? (~dy_s + DIFF_W'(1)) : dy_s;
            b_nxt     = t_s[DIFF_W-1] ? '0 : t_s;
            dx_nxt    = dx_s[DIFF_W-1] ? '0 : dx_s;
            state_nxt = ST_MUL0;
          end
        end else if (CNT_W'(k_r) + CNT_W'(1) == n_eff) begin
          out_valid_nxt  = 1'b1;
          out_y_nxt      = y_rd_r;
          out_status_nxt = STATUS_OK;
          state_nxt      = ST_IDLE;
        end else begin
          x_prev_nxt = x_rd_r;
          y_prev_nxt = y_rd_r;
          k_nxt      = k_r + IDX_W'(1);
        end
      end
      ST_MUL0: begin
        acc_nxt   = PROD_W'(pp);
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        rem_nxt   = prod_full[PROD_W-1:DIFF_W];
        dq_nxt    = prod_full[DIFF_W-1:0];
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!trial[DIFF_W]) begin
          rem_nxt = trial[DIFF_W-1:0];
        end else begin
          rem_nxt = {rem_r[DIFF_W-2:0], dq_r[DIFF_W-1]};
        end
        dq_nxt  = {dq_r[DIFF_W-2:0], ~trial[DIFF_W]};
        cnt_nxt = cnt_r + DCNT_W'(1);
        if (cnt_r == DCNT_W'(DIFF_W - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        out_valid_nxt  = 1'b1;
        out_y_nxt      = sum[VALUE_W-1:0];
        out_status_nxt = STATUS_OK;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      piu_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      piu_r       <= piu_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    q_r          <= q_nxt;
    x_prev_r     <= x_prev_nxt;
    y_prev_r     <= y_prev_nxt;
    neg_r        <= neg_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    dx_r         <= dx_nxt;
    acc_r        <= acc_nxt;
    rem_r        <= rem_nxt;
    dq_r         <= dq_nxt;
    cnt_r        <= cnt_nxt;
    out_y_r      <= out_y_nxt;
    out_status_r <= out_status_nxt;
  end

`ifndef NO_ASSERTIONS
  // a result only follows an evaluate word or work in progress
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || (start && (in_opcode == OP_EVAL))))
    else $error("result word without an evaluate word");

  // a load word never yields a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_opcode == OP_LOAD)) |=> !out_valid)
    else $error("result word after a load word");

  // the segment width is positive once a segment is chosen
  a_dx_positive: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL0) |-> (dx_r != '0))
    else $error("zero segment width");

  // the quotient never exceeds the y step
  a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |-> (dq_r <= a_r))
    else $error("quotient above y step");
`endif

endmodule

>>> verif/piecewise_linear_interpolator_tb.sv
// self-checking testbench for the piecewise linear interpolator: directed and random tables
module piecewise_linear_interpolator_tb;
  import pwli_pkg::*;

  localparam int IDLE_PCT   = 32;
  localparam int DRAIN_WAIT = 60;
  localparam int STALL_MAX  = 4000;
  localparam int PHASES     = 16;
  localparam int PHASE_LEN  = 70;
  localparam logic [CFG_ADDR_W-1:0] PIU_ADDR = CFG_ADDR_W'(REG_POINTS_IN_USE) << 2;

  typedef struct packed {
    logic signed [VALUE_W-1:0] y_result;
    logic                      status;
  } interp_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_opcode = OP_LOAD;
  logic [PIDX_W-1:0] in_point_index = '0;
  logic signed [VALUE_W-1:0] in_x_value = '0;
  logic signed [VALUE_W-1:0] in_y_value = '0;
  logic out_valid;
  logic signed [VALUE_W-1:0] out_y_result;
  logic out_status;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  logic signed [VALUE_W-1:0] table_x [MAX_POINTS];
  logic signed [VALUE_W-1:0] table_y [MAX_POINTS];
  logic [CFG_PIU_W-1:0]      points_in_use = '0;
  interp_result_t            expected_y[$];
  interp_result_t            oldest;

  bit idle_on = 1'b1;
  int errors = 0;
  int loads_sent = 0;
  int evals_sent = 0;
  int results_seen = 0;
  int empty_seen = 0;
  int stall_cycles = 0;

  piecewise_linear_interpolator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_point_index(in_point_index),
    .in_x_value(in_x_value), .in_y_value(in_y_value),
    .out_valid(out_valid), .out_y_result(out_y_result), .out_status(out_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // updates the table on a load, queues the expected interpolated value on an evaluation
  function automatic void predict_interp(input logic op, input logic [PIDX_W-1:0] idx,
                                         input logic signed [VALUE_W-1:0] xv,
                                         input logic signed [VALUE_W-1:0] yv);
    int n;
    int k;
    longint dy;
    longint dx;
    longint t;
    logic neg;
    logic [63:0] mag_dy;
    logic [63:0] mag_t;
    logic [63:0] mag_dx;
    logic [127:0] prod;
    logic [127:0] quo;
    interp_result_t r;
    if (op == OP_LOAD) begin
      if (int'(idx) < MAX_POINTS) begin
        table_x[idx] = xv;
        table_y[idx] = yv;
      end
      return;
    end
    n = (int'(points_in_use) > MAX_POINTS) ? MAX_POINTS : int'(points_in_use);
    r.status = STATUS_OK;
    if (n == 0) begin
      r.y_result = '0;
      r.status = STATUS_EMPTY;
    end else begin
      k = 0;
      while (k < n && table_x[k] < xv) k++;
      if (k == n) begin
        r.y_result = table_y[n-1];
      end else if (k == 0) begin
        r.y_result = table_y[0];
      end else begin
        dy = longint'(table_y[k]) - longint'(table_y[k-1]);
        dx = longint'(table_x[k]) - longint'(table_x[k-1]);
        t = longint'(xv) - longint'(table_x[k-1]);
        neg = dy < 0;
        mag_dy = neg ? 64'(-dy) : 64'(dy);
        mag_t = (t < 0) ? 64'd0 : 64'(t);
        mag_dx = (dx < 0) ? 64'd0 : 64'(dx);
        prod = {64'd0, mag_dy} * {64'd0, mag_t};
        quo = (mag_dx == 0) ? 128'd0 : prod / {64'd0, mag_dx};
        r.y_result = table_y[k-1] + (neg ? -quo[VALUE_W-1:0] : quo[VALUE_W-1:0]);
      end
    end
    expected_y = {expected_y, r};
  endfunction

  task automatic issue_word(input logic op, input logic [PIDX_W-1:0] idx,
                            input logic signed [VALUE_W-1:0] xv,
                            input logic signed [VALUE_W-1:0] yv);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_opcode <= op;
    in_point_index <= idx;
    in_x_value <= xv;
    in_y_value <= yv;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_interp(op, idx, xv, yv);
    if (op == OP_LOAD) loads_sent++;
    else evals_sent++;
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (expected_y.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic set_points_in_use(input logic [CFG_PIU_W-1:0] v);
    hold_until_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= PIU_ADDR;
    pwdata <= CFG_DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    points_in_use = v;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== CFG_DATA_W'(v)) begin
      $error("points_in_use read back: expected %0d, actual %0d", v, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_empty_table();
    issue_word(OP_EVAL, '0, 32'sh8000_0000, '0);
    issue_word(OP_EVAL, '1, 32'sh7fff_ffff, 32'sh7fff_ffff);
  endtask

  task automatic test_extreme_segments();
    issue_word(OP_LOAD, 4'd0, 32'sh8000_0000, 32'sh7fff_ffff);
    issue_word(OP_LOAD, 4'd1, 32'sh0000_0000, 32'sh8000_0000);
    issue_word(OP_LOAD, 4'd2, 32'sh7fff_0000, 32'sh0001_0000);
    set_points_in_use(5'd3);
    issue_word(OP_EVAL, '0, 32'sh8000_0000, '0);
    issue_word(OP_EVAL, '0, 32'shffff_ffff, '0);
    issue_word(OP_EVAL, '0, 32'sh0000_0000, '0);
    issue_word(OP_EVAL, '0, 32'sh4000_0000, '0);
    issue_word(OP_EVAL, '0, 32'sh7fff_ffff, '0);
  endtask

  task automatic test_single_point();
    set_points_in_use(5'd1);
    issue_word(OP_EVAL, '0, 32'sh8000_0000, '0);
    issue_word(OP_EVAL, '0, 32'sh7fff_ffff, '0);
  endtask

  task automatic test_random_tables();
    int tx[$];
    int n;
    int i;
    int r;
    bit narrow;
    longint lo;
    longint hi;
    logic signed [VALUE_W-1:0] q;
    for (int p = 0; p < PHASES; p++) begin
      case (p % 6)
        0: n = 0;
        1: n = 1;
        2: n = MAX_POINTS;
        3: n = 31;
        4: n = $urandom_range(MAX_POINTS - 1, 2);
        default: n = $urandom_range(30, MAX_POINTS + 1);
      endcase
      idle_on = !(p >= 6 && p <= 8);
      set_points_in_use(CFG_PIU_W'(n));
      narrow = $urandom_range(1);
      tx.delete();
      for (i = 0; i < MAX_POINTS; i++)
        tx = {tx, (narrow ? int'($urandom_range(4000)) - 2000 : int'($urandom))};
      tx.sort();
      for (i = 0; i < MAX_POINTS; i++)
        issue_word(OP_LOAD, PIDX_W'(i), tx[i],
                   narrow ? int'($urandom_range(1 << 20)) - (1 << 19) : int'($urandom));
      for (int j = 0; j < PHASE_LEN; j++) begin
        if (p == 10 && j == PHASE_LEN / 2) hold_until_drained();
        r = $urandom_range(99);
        if (r < 12) begin
          issue_word(OP_LOAD, PIDX_W'($urandom), $urandom, $urandom);
        end else begin
          i = $urandom_range(MAX_POINTS - 2);
          case ($urandom_range(3))
            0: q = tx[i];
            1: q = tx[i] + $urandom_range(3) - 1;
            2: q = $urandom;
            default: begin
              lo = tx[i];
              hi = tx[i+1];
              q = VALUE_W'(lo + longint'($urandom) % (hi - lo + 1));
            end
          endcase
          issue_word(OP_EVAL, PIDX_W'($urandom), q, $urandom);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_y.size() == 0) begin
        $error("unexpected result: y_result %0d status %0d", out_y_result, out_status);
        errors++;
      end else begin
        oldest = expected_y.pop_front();
        results_seen++;
        if (out_status == STATUS_EMPTY) empty_seen++;
        if (out_y_result !== oldest.y_result) begin
          $error("y_result: expected %0d, actual %0d", oldest.y_result, out_y_result);
          errors++;
        end
        if (out_status !== oldest.status) begin
          $error("status: expected %0d, actual %0d", oldest.status, out_status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("piecewise_linear_interpolator verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < MAX_POINTS; i++) begin
      table_x[i] = '0;
      table_y[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_extreme_segments();
    test_single_point();
    test_random_tables();
    hold_until_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("%0d words sent: %0d loads, %0d evaluations; %0d results checked, %0d empty",
             loads_sent + evals_sent, loads_sent, evals_sent, results_seen, empty_seen);
    $display("table sizes 0 to 31 used, sorted tables with random loads mixed in");
    if (errors == 0) begin
      $display("piecewise_linear_interpolator verification clean");
    end else begin
      $display("piecewise_linear_interpolator verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/pwli_pkg.sv
hdl/piecewise_linear_interpolator.sv
verif/piecewise_linear_interpolator_tb.sv
